/* hw/rtl/mec_pkg.sv */
`default_nettype none

package mec_pkg;

    localparam int FRAC_BITS = 26;
    localparam int ITER_BITS = 16;
    localparam int MAX_WIDTH = 4096;

    localparam int COORD_W   = 32;
    localparam int POS_W     = 12;
    localparam int WIDTH_W   = 13;
    localparam int IDX_W     = 24;
    localparam int CFG_IDX_W = 3;
    localparam int PROD_W    = 2 * COORD_W;
    // Widest value that is ever clamped to the coordinate range.
    localparam int SAT_IN_W  = COORD_W + POS_W + 2;

    // Escape threshold 4.0 in the format of the full-width squares.
    localparam logic [PROD_W-1:0] ESCAPE_LIMIT = PROD_W'(4) << (2 * FRAC_BITS);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_X_START   = 3'd0,
        REG_Y_START   = 3'd1,
        REG_X_STEP    = 3'd2,
        REG_Y_STEP    = 3'd3,
        REG_WIDTH     = 3'd4,
        REG_MAX_ITER  = 3'd5
    } t_cfg_reg;

    typedef struct packed {
        logic [POS_W-1:0] column;
        logic [POS_W-1:0] row;
    } t_in_item;

    typedef struct packed {
        logic [IDX_W-1:0]     pixel_index;
        logic [ITER_BITS-1:0] iteration_count;
    } t_out_item;

    typedef struct packed {
        logic capture;
        logic setup_mul;
        logic setup_add;
        logic iter_mul;
        logic iter_upd;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic at_limit;
        logic escaped;
    } t_dp_status;

    // Clamp a signed value to the signed coordinate range: it fits when all
    // bits above the coordinate's sign bit agree with it.
    function automatic logic signed [COORD_W-1:0] sat_coord(
        input logic signed [SAT_IN_W-1:0] v
    );
        logic [SAT_IN_W-COORD_W:0] upper;
        logic signed [COORD_W-1:0] res;
        upper = v[SAT_IN_W-1:COORD_W-1];
        if ((&upper) || !(|upper)) begin
            res = v[COORD_W-1:0];
        end else if (v[SAT_IN_W-1]) begin
            res = {1'b1, {(COORD_W-1){1'b0}}};
        end else begin
            res = {1'b0, {(COORD_W-1){1'b1}}};
        end
        return res;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/mec_ctrl.sv */
`default_nettype none

module mec_ctrl (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    input  wire mec_pkg::t_dp_status i_status,
    output mec_pkg::t_dp_cmd         o_cmd
);

    typedef enum logic [5:0] {
        ST_IDLE      = 6'b000001,
        ST_SETUP_MUL = 6'b000010,
        ST_SETUP_ADD = 6'b000100,
        ST_ITER_MUL  = 6'b001000,
        ST_ITER_UPD  = 6'b010000,
        ST_FINISH    = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_SETUP_MUL;
                end
            end
            ST_SETUP_MUL: begin
                o_cmd.setup_mul = 1'b1;
                n_state         = ST_SETUP_ADD;
            end
            ST_SETUP_ADD: begin
                o_cmd.setup_add = 1'b1;
                n_state         = ST_ITER_MUL;
            end
            ST_ITER_MUL: begin
                if (i_status.at_limit) begin
                    n_state = ST_FINISH;
                end else begin
                    o_cmd.iter_mul = 1'b1;
                    n_state        = ST_ITER_UPD;
                end
            end
            ST_ITER_UPD: begin
                if (i_status.escaped) begin
                    n_state = ST_FINISH;
                end else begin
                    o_cmd.iter_upd = 1'b1;
                    n_state        = ST_ITER_MUL;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

/* hw/rtl/mec_datapath.sv */
`default_nettype none

module mec_datapath (
    input  wire logic                                 i_clk,
    input  wire mec_pkg::t_dp_cmd                     i_cmd,
    input  wire mec_pkg::t_in_item                    i_in_data,
    input  wire logic signed [mec_pkg::COORD_W-1:0]   i_x_start,
    input  wire logic signed [mec_pkg::COORD_W-1:0]   i_y_start,
    input  wire logic signed [mec_pkg::COORD_W-1:0]   i_x_step,
    input  wire logic signed [mec_pkg::COORD_W-1:0]   i_y_step,
    input  wire logic        [mec_pkg::WIDTH_W-1:0]   i_width,
    input  wire logic        [mec_pkg::ITER_BITS-1:0] i_max_iter,
    output mec_pkg::t_dp_status                       o_status,
    output mec_pkg::t_out_item                        o_out_data
);

    localparam int CPROD_W = mec_pkg::COORD_W + mec_pkg::POS_W + 1;
    localparam int IPROD_W = mec_pkg::POS_W + mec_pkg::WIDTH_W;

    logic        [mec_pkg::POS_W-1:0]     r_col;
    logic        [mec_pkg::POS_W-1:0]     r_row;
    logic signed [CPROD_W-1:0]            r_xprod;
    logic signed [CPROD_W-1:0]            r_yprod;
    logic        [IPROD_W-1:0]            r_iprod;
    logic        [mec_pkg::IDX_W-1:0]     r_idx;
    logic signed [mec_pkg::COORD_W-1:0]   r_cr;
    logic signed [mec_pkg::COORD_W-1:0]   r_ci;
    logic signed [mec_pkg::COORD_W-1:0]   r_zr;
    logic signed [mec_pkg::COORD_W-1:0]   r_zi;
    logic signed [mec_pkg::PROD_W-1:0]    r_rr;
    logic signed [mec_pkg::PROD_W-1:0]    r_ii;
    logic signed [mec_pkg::PROD_W-1:0]    r_ri;
    logic        [mec_pkg::ITER_BITS-1:0] r_iter;
    mec_pkg::t_out_item                   r_out;

    logic        [mec_pkg::WIDTH_W-1:0]   width_eff;
    logic signed [mec_pkg::SAT_IN_W-1:0]  x_sum;
    logic signed [mec_pkg::SAT_IN_W-1:0]  y_sum;
    logic signed [mec_pkg::PROD_W-1:0]    diff;
    logic signed [mec_pkg::SAT_IN_W-1:0]  zr_sum;
    logic signed [mec_pkg::SAT_IN_W-1:0]  zi_sum;
    logic        [mec_pkg::PROD_W-1:0]    mag_sum;

    assign width_eff = (i_width > mec_pkg::WIDTH_W'(mec_pkg::MAX_WIDTH))
                     ? mec_pkg::WIDTH_W'(mec_pkg::MAX_WIDTH) : i_width;

    assign x_sum = mec_pkg::SAT_IN_W'(i_x_start) + mec_pkg::SAT_IN_W'(r_xprod);
    assign y_sum = mec_pkg::SAT_IN_W'(i_y_start) + mec_pkg::SAT_IN_W'(r_yprod);

    // The arithmetic shifts round towards minus infinity, as required.
    assign diff   = r_rr - r_ii;
    assign zr_sum = mec_pkg::SAT_IN_W'($signed(diff[mec_pkg::PROD_W-1:mec_pkg::FRAC_BITS]))
                  + mec_pkg::SAT_IN_W'(r_cr);
    assign zi_sum = mec_pkg::SAT_IN_W'($signed(r_ri[mec_pkg::PROD_W-1:mec_pkg::FRAC_BITS-1]))
                  + mec_pkg::SAT_IN_W'(r_ci);

    // Both squares are non-negative and at most 2^62, so the sum cannot wrap.
    assign mag_sum = $unsigned(r_rr) + $unsigned(r_ii);

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_col <= i_in_data.column;
            r_row <= i_in_data.row;
        end
        if (i_cmd.setup_mul) begin
            r_xprod <= $signed({1'b0, r_col}) * i_x_step;
            r_yprod <= $signed({1'b0, r_row}) * i_y_step;
            r_iprod <= IPROD_W'(r_row) * IPROD_W'(width_eff);
        end
        if (i_cmd.setup_add) begin
            r_cr   <= mec_pkg::sat_coord(x_sum);
            r_ci   <= mec_pkg::sat_coord(y_sum);
            r_zr   <= mec_pkg::sat_coord(x_sum);
            r_zi   <= mec_pkg::sat_coord(y_sum);
            r_idx  <= r_iprod[mec_pkg::IDX_W-1:0] + mec_pkg::IDX_W'(r_col);
            r_iter <= '0;
        end
        if (i_cmd.iter_mul) begin
            r_rr <= r_zr * r_zr;
            r_ii <= r_zi * r_zi;
            r_ri <= r_zr * r_zi;
        end
        if (i_cmd.iter_upd) begin
            r_zr   <= mec_pkg::sat_coord(zr_sum);
            r_zi   <= mec_pkg::sat_coord(zi_sum);
            r_iter <= r_iter + mec_pkg::ITER_BITS'(1);
        end
        if (i_cmd.load_out) begin
            r_out.pixel_index     <= r_idx;
            r_out.iteration_count <= r_iter;
        end
    end

    assign o_status.at_limit = (r_iter == i_max_iter);
    assign o_status.escaped  = (mag_sum > mec_pkg::ESCAPE_LIMIT);
    assign o_out_data        = r_out;

endmodule

`default_nettype wire

/* hw/rtl/mandelbrot_escape_count_top.sv */
// A pixel finishes when it escapes or when it reaches the step limit.
// Each escape step computes three 32x32 products, then the update.
// A new pixel is taken the cycle after the previous result enters the output register.
// Reset (synchronous, active low) clears the controller and loads the register defaults.
`default_nettype none

module mandelbrot_escape_count_top (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_stall,
    input  wire mec_pkg::t_in_item                 i_in_data,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_stall,
    output mec_pkg::t_out_item                     o_out_data,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [mec_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [mec_pkg::COORD_W-1:0]       i_cfg_data
);

    logic signed [mec_pkg::COORD_W-1:0]   r_x_start;
    logic signed [mec_pkg::COORD_W-1:0]   r_y_start;
    logic signed [mec_pkg::COORD_W-1:0]   r_x_step;
    logic signed [mec_pkg::COORD_W-1:0]   r_y_step;
    logic        [mec_pkg::WIDTH_W-1:0]   r_width;
    logic        [mec_pkg::ITER_BITS-1:0] r_max_iter;

    mec_pkg::t_dp_cmd    cmd;
    mec_pkg::t_dp_status status;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_start  <= '0;
            r_y_start  <= '0;
            r_x_step   <= '0;
            r_y_step   <= '0;
            r_width    <= mec_pkg::WIDTH_W'(1);
            r_max_iter <= mec_pkg::ITER_BITS'(256);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                mec_pkg::REG_X_START:  r_x_start  <= i_cfg_data;
                mec_pkg::REG_Y_START:  r_y_start  <= i_cfg_data;
                mec_pkg::REG_X_STEP:   r_x_step   <= i_cfg_data;
                mec_pkg::REG_Y_STEP:   r_y_step   <= i_cfg_data;
                mec_pkg::REG_WIDTH:    r_width    <= i_cfg_data[mec_pkg::WIDTH_W-1:0];
                mec_pkg::REG_MAX_ITER: r_max_iter <= i_cfg_data[mec_pkg::ITER_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    mec_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    mec_datapath u_datapath (
        .i_clk      (i_clk),
        .i_cmd      (cmd),
        .i_in_data  (i_in_data),
        .i_x_start  (r_x_start),
        .i_y_start  (r_y_start),
        .i_x_step   (r_x_step),
        .i_y_step   (r_y_step),
        .i_width    (r_width),
        .i_max_iter (r_max_iter),
        .o_status   (status),
        .o_out_data (o_out_data)
    );

endmodule

`default_nettype wire

/* hw/rtl/mec_checker.sv */
`default_nettype none

module mec_checker (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    input  wire logic                          o_in_stall,
    input  wire logic                          o_out_valid,
    input  wire logic                          i_out_stall,
    input  wire mec_pkg::t_out_item            o_out_data
);

    logic       in_xfer;
    logic       out_xfer;
    logic [1:0] r_pending;

    assign in_xfer  = i_in_valid && !o_in_stall;
    assign out_xfer = o_out_valid && !i_out_stall;

    // Pixels taken in whose results have not yet been transferred out.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else begin
            r_pending <= r_pending + {1'b0, in_xfer} - {1'b0, out_xfer};
        end
    end

    // The block works on one pixel at a time.
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> o_in_stall)
        else $error("input taken while a pixel is still in work");

    // No result appears while set-up and the first limit check run.
    a_min_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> !$rose(o_out_valid) ##1 !$rose(o_out_valid) ##1 !$rose(o_out_valid))
        else $error("result appeared too early after an input transfer");

    a_no_extra_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_xfer |-> (r_pending != 2'd0))
        else $error("result transferred with no pixel outstanding");

    a_pending_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |-> (r_pending <= 2'd1))
        else $error("input taken while two pixels are outstanding");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled result changed or vanished");

endmodule

bind mandelbrot_escape_count_top mec_checker u_mec_checker (.*);

`default_nettype wire
